[rtl/heap_sort_engine_defines.svh]
// assertion macros shared by the rtl
`ifndef HEAP_SORT_ENGINE_DEFINES_SVH
`define HEAP_SORT_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge outside reset
`define HSE_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define HSE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define HSE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define HSE_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define HSE_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define HSE_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/hse_pkg.sv]
package hse_pkg;

   localparam int unsigned KEY_W = 32;

   typedef logic signed [KEY_W-1:0] key_type;

   // signed key compare, a < b
   function automatic logic key_less(input key_type a, input key_type b);
      return a < b;
   endfunction

endpackage

[rtl/heap_sort_engine.sv]
// channel  | direction | ports
// ---------+-----------+----------------------------------------------------
// req      | in        | req_valid, req_ready, req_key, req_final_key
// rsp      | out       | rsp_valid, rsp_ready, rsp_sorted_key, rsp_run_end,
//          |           | rsp_overflowed
//
// Loading accepts one key per cycle. The transfer marked final starts the sort,
// which runs on one key memory and one signed comparator. Results then leave
// one at a time: the next key is read from memory only after the previous
// result is taken. req_ready stays low from the final transfer until the last
// result of the run is taken.
// Reset is synchronous and clears control state; the key memory is not cleared.
`include "heap_sort_engine_defines.svh"

module heap_sort_engine #(
   parameter int STORE_DEPTH = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  hse_pkg::key_type req_key,
   input  logic            req_final_key,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output hse_pkg::key_type rsp_sorted_key,
   output logic            rsp_run_end,
   output logic            rsp_overflowed
);

   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CW = $clog2(STORE_DEPTH + 1);

   localparam logic [3:0] S_LOAD      = 4'd0;
   localparam logic [3:0] S_TOP       = 4'd1;
   localparam logic [3:0] S_CUR       = 4'd2;
   localparam logic [3:0] S_LEFT      = 4'd3;
   localparam logic [3:0] S_RIGHT     = 4'd4;
   localparam logic [3:0] S_CMP       = 4'd5;
   localparam logic [3:0] S_NEXT      = 4'd6;
   localparam logic [3:0] S_PUT       = 4'd7;
   localparam logic [3:0] S_SWAP_A    = 4'd8;
   localparam logic [3:0] S_SWAP_B    = 4'd9;
   localparam logic [3:0] S_SWAP_C    = 4'd10;
   localparam logic [3:0] S_EMIT_RD   = 4'd11;
   localparam logic [3:0] S_EMIT_LD   = 4'd12;
   localparam logic [3:0] S_EMIT_WAIT = 4'd13;

   // control registers
   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          drop_ff, drop_in;
   logic          phase_ff, phase_in;
   logic [AW-1:0] top_ff, top_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] heap_len_ff, heap_len_in;
   logic [AW-1:0] last_ff, last_in;
   logic [AW-1:0] big_idx_ff, big_idx_in;
   logic [AW-1:0] emit_idx_ff, emit_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload registers
   hse_pkg::key_type cur_ff, cur_in;
   hse_pkg::key_type big_ff, big_in;
   hse_pkg::key_type rd_ff;
   hse_pkg::key_type out_key_ff, out_key_in;
   logic             out_end_ff, out_end_in;
   logic             out_ovf_ff, out_ovf_in;

   // memory port and shared comparator
   hse_pkg::key_type key_mem [STORE_DEPTH];
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   hse_pkg::key_type wr_data;
   logic [AW-1:0]    rd_addr;
   hse_pkg::key_type cmp_a, cmp_b;
   logic             cmp_lt;

   logic [CW:0]   child_w, right_w, len_w;
   logic [CW-1:0] half_w;

   assign child_w = (CW+1)'({pos_ff, 1'b1});
   assign right_w = child_w + (CW+1)'(1);
   assign len_w   = (CW+1)'(heap_len_ff);
   assign cmp_lt  = hse_pkg::key_less(cmp_a, cmp_b);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      phase_in     = phase_ff;
      top_in       = top_ff;
      pos_in       = pos_ff;
      heap_len_in  = heap_len_ff;
      last_in      = last_ff;
      big_idx_in   = big_idx_ff;
      emit_idx_in  = emit_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      cur_in       = cur_ff;
      big_in       = big_ff;
      out_key_in   = out_key_ff;
      out_end_in   = out_end_ff;
      out_ovf_in   = out_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = cur_ff;
      rd_addr      = '0;
      cmp_a        = cur_ff;
      cmp_b        = big_ff;
      half_w       = '0;

      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (count_ff < CW'(STORE_DEPTH)) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  wr_data  = req_key;
                  count_in = count_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_final_key) begin
                  emit_idx_in = '0;
                  if (count_in >= CW'(2)) begin
                     half_w      = (count_in >> 1) - CW'(1);
                     phase_in    = 1'b0;
                     heap_len_in = count_in;
                     top_in      = half_w[AW-1:0];
                     pos_in      = half_w[AW-1:0];
                     state_in    = S_TOP;
                  end else begin
                     state_in = S_EMIT_RD;
                  end
               end
            end
         end
         S_TOP: begin
            rd_addr  = pos_ff;
            state_in = S_CUR;
         end
         S_CUR, S_NEXT: begin
            if (state_ff == S_CUR) begin
               cur_in = rd_ff;
            end
            if (child_w < len_w) begin
               rd_addr  = child_w[AW-1:0];
               state_in = S_LEFT;
            end else begin
               state_in = S_PUT;
            end
         end
         S_LEFT: begin
            big_in     = rd_ff;
            big_idx_in = child_w[AW-1:0];
            if (right_w < len_w) begin
               rd_addr  = right_w[AW-1:0];
               state_in = S_RIGHT;
            end else begin
               state_in = S_CMP;
            end
         end
         S_RIGHT: begin
            cmp_a = big_ff;
            cmp_b = rd_ff;
            if (cmp_lt) begin
               big_in     = rd_ff;
               big_idx_in = right_w[AW-1:0];
            end
            state_in = S_CMP;
         end
         S_CMP: begin
            // larger child moves up into the hole
            if (cmp_lt) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff;
               wr_data  = big_ff;
               pos_in   = big_idx_ff;
               state_in = S_NEXT;
            end else begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = cur_ff;
            if (!phase_ff) begin
               if (top_ff == '0) begin
                  phase_in = 1'b1;
                  half_w   = count_ff - CW'(1);
                  last_in  = half_w[AW-1:0];
                  state_in = S_SWAP_A;
               end else begin
                  top_in   = top_ff - AW'(1);
                  pos_in   = top_ff - AW'(1);
                  state_in = S_TOP;
               end
            end else begin
               if (heap_len_ff == CW'(1)) begin
                  emit_idx_in = '0;
                  state_in    = S_EMIT_RD;
               end else begin
                  half_w   = heap_len_ff - CW'(1);
                  last_in  = half_w[AW-1:0];
                  state_in = S_SWAP_A;
               end
            end
         end
         S_SWAP_A: begin
            rd_addr  = '0;
            state_in = S_SWAP_B;
         end
         S_SWAP_B: begin
            big_in   = rd_ff;
            rd_addr  = last_ff;
            state_in = S_SWAP_C;
         end
         S_SWAP_C: begin
            // root goes to the end, old end key re-sifts from the root
            cur_in      = rd_ff;
            wr_en       = 1'b1;
            wr_addr     = last_ff;
            wr_data     = big_ff;
            pos_in      = '0;
            heap_len_in = CW'(last_ff);
            state_in    = S_NEXT;
         end
         S_EMIT_RD: begin
            rd_addr  = emit_idx_ff;
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            out_key_in   = rd_ff;
            out_end_in   = (CW'(emit_idx_ff) + CW'(1)) == count_ff;
            out_ovf_in   = drop_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (out_end_ff) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  emit_idx_in = emit_idx_ff + AW'(1);
                  state_in    = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         phase_ff     <= 1'b0;
         top_ff       <= '0;
         pos_ff       <= '0;
         heap_len_ff  <= '0;
         last_ff      <= '0;
         big_idx_ff   <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         phase_ff     <= phase_in;
         top_ff       <= top_in;
         pos_ff       <= pos_in;
         heap_len_ff  <= heap_len_in;
         last_ff      <= last_in;
         big_idx_ff   <= big_idx_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      big_ff     <= big_in;
      out_key_ff <= out_key_in;
      out_end_ff <= out_end_in;
      out_ovf_ff <= out_ovf_in;
   end

   // key memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_data;
      end
      rd_ff <= key_mem[rd_addr];
   end

   assign req_ready      = (state_ff == S_LOAD);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sorted_key = out_key_ff;
   assign rsp_run_end    = out_end_ff;
   assign rsp_overflowed = out_ovf_ff;

   // checks
   `HSE_ASSERT_ALWAYS(a_no_load_while_emit, clock, reset, !(req_ready && rsp_valid))
   `HSE_ASSERT_ALWAYS(a_count_in_range, clock, reset, count_ff <= CW'(STORE_DEPTH))
   `HSE_ASSERT_NEXT(a_ready_after_run, clock, reset, rsp_valid && rsp_ready && rsp_run_end, req_ready && (count_ff == '0))
   `HSE_ASSERT_SAME(a_heap_within_set, clock, reset, !req_ready, heap_len_ff <= count_ff)

endmodule
